>>> src/i2c_master_write_sequencer_unit_macros.svh
// assertion macros for the i2c master write sequencer
`ifndef I2C_MASTER_WRITE_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_WRITE_SEQUENCER_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define I2CMWS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("i2cmws assertion failed");

// checked on every clock edge, reset included
`define I2CMWS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("i2cmws assertion failed");

`endif

>>> src/i2cmws_pkg.sv
// types, codes and constants for the i2c master write sequencer
package i2cmws_pkg;

    localparam int MAX_BYTES_DEF = 4;

    localparam logic [7:0] STATUS_MASK = 8'hF8;
    localparam logic [7:0] ST_STARTED  = 8'h08;
    localparam logic [7:0] ST_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STARTING,
        PH_ADDRESSING,
        PH_SENDING
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_TX    = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_ACK   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_START_FAILED = 2'd1,
        ERR_NOT_READY    = 2'd2
    } t_err;

    typedef enum logic {
        REQ_SEND  = 1'b0,
        REQ_EVENT = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type  req_type;
        logic [6:0] slave_addr;
        logic [2:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [7:0] bus_status;
    } t_req_item;

    typedef struct packed {
        logic       accepted;
        t_cmd       bus_command;
        logic [7:0] tx_byte;
        t_err       error_code;
        logic       seq_busy;
    } t_res_item;

endpackage

>>> src/i2cmws_req_if.sv
// request / bus event channel
interface i2cmws_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [6:0] slave_addr;
    logic [2:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [7:0] bus_status;

    modport source (
        output valid, req_type, slave_addr, byte_count,
               first_byte, second_byte, third_byte, fourth_byte, bus_status,
        input  ready
    );
    modport sink (
        input  valid, req_type, slave_addr, byte_count,
               first_byte, second_byte, third_byte, fourth_byte, bus_status,
        output ready
    );
endinterface

>>> src/i2cmws_res_if.sv
// result channel
interface i2cmws_res_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic [1:0] error_code;
    logic       seq_busy;

    modport source (
        output valid, accepted, bus_command, tx_byte, error_code, seq_busy,
        input  ready
    );
    modport sink (
        input  valid, accepted, bus_command, tx_byte, error_code, seq_busy,
        output ready
    );
endinterface

>>> src/i2c_master_write_sequencer_unit.sv
// i2c master write sequencer: input register, decision logic, result register
// path: an input word passes the decision logic into the result register
// throughput: one word per cycle while not stalled; the state update sits between the two registers
// back-pressure: a full result register not being read stalls the input register, then the input
// reset: synchronous active low, clears both registers' valid bits, phase,
// counters, address and error; the byte store keeps its contents
module i2c_master_write_sequencer_unit #(
    parameter int MAX_BYTES = i2cmws_pkg::MAX_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cmws_req_if.sink   i_req,
    i2cmws_res_if.source o_res
);

    logic                  w_in_valid;
    i2cmws_pkg::t_req_item w_item;
    i2cmws_pkg::t_res_item w_res;
    logic                  w_out_ready;
    logic                  w_fire;

    assign w_fire = w_in_valid && w_out_ready;

    i2cmws_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_down_ready (w_out_ready),
        .o_valid      (w_in_valid),
        .o_item       (w_item)
    );

    i2cmws_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (w_item),
        .o_res   (w_res)
    );

    i2cmws_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_res   (w_res),
        .o_ready (w_out_ready),
        .o_res   (o_res)
    );

endmodule

>>> src/i2cmws_in_stage.sv
// input register for request and event words
module i2cmws_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2cmws_req_if.sink            i_req,
    input  logic                  i_down_ready,
    output logic                  o_valid,
    output i2cmws_pkg::t_req_item o_item
);

    logic                  r_valid;
    i2cmws_pkg::t_req_item r_item;
    logic                  w_take;

    assign i_req.ready = !r_valid || i_down_ready;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.req_type    <= i2cmws_pkg::t_req_type'(i_req.req_type);
            r_item.slave_addr  <= i_req.slave_addr;
            r_item.byte_count  <= i_req.byte_count;
            r_item.first_byte  <= i_req.first_byte;
            r_item.second_byte <= i_req.second_byte;
            r_item.third_byte  <= i_req.third_byte;
            r_item.fourth_byte <= i_req.fourth_byte;
            r_item.bus_status  <= i_req.bus_status;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/i2cmws_core.sv
// sequencer state and the decision for one word
module i2cmws_core #(
    parameter int MAX_BYTES = i2cmws_pkg::MAX_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cmws_pkg::t_req_item i_item,
    output i2cmws_pkg::t_res_item o_res
);

    localparam int IW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW   = $clog2(MAX_BYTES + 1);
    localparam int CMPW = (IW + 1 > CW) ? IW + 1 : CW;

    i2cmws_pkg::t_phase r_phase, n_phase;
    i2cmws_pkg::t_err   r_err, n_err;
    logic [IW-1:0]      r_idx, n_idx;
    logic [6:0]         r_addr, n_addr;
    logic [CW-1:0]      r_count, n_count;
    logic [7:0]         r_store [MAX_BYTES];

    logic               w_load;
    logic [7:0]         w_in_bytes [4];
    logic [7:0]         w_status;
    logic [IW:0]        w_next_idx;
    logic [7:0]         w_next_byte;
    logic               w_last;

    assign w_in_bytes[0] = i_item.first_byte;
    assign w_in_bytes[1] = i_item.second_byte;
    assign w_in_bytes[2] = i_item.third_byte;
    assign w_in_bytes[3] = i_item.fourth_byte;

    assign w_status   = i_item.bus_status & i2cmws_pkg::STATUS_MASK;
    assign w_next_idx = {1'b0, r_idx} + (IW + 1)'(1);
    assign w_last     = CMPW'(w_next_idx) >= CMPW'(r_count);

    // entries past the end of the byte store read as zero
    always_comb begin
        if (int'(w_next_idx) < MAX_BYTES) begin
            w_next_byte = r_store[w_next_idx[IW-1:0]];
        end else begin
            w_next_byte = 8'd0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_count = r_count;
        w_load  = 1'b0;

        o_res.accepted    = 1'b0;
        o_res.bus_command = i2cmws_pkg::CMD_NONE;
        o_res.tx_byte     = 8'd0;

        if (i_item.req_type == i2cmws_pkg::REQ_SEND) begin
            if (r_phase == i2cmws_pkg::PH_IDLE) begin
                w_load  = 1'b1;
                n_addr  = i_item.slave_addr;
                if (int'(i_item.byte_count) > MAX_BYTES) begin
                    n_count = CW'(MAX_BYTES);
                end else begin
                    n_count = CW'(i_item.byte_count);
                end
                n_idx   = '0;
                n_phase = i2cmws_pkg::PH_STARTING;
                o_res.accepted    = 1'b1;
                o_res.bus_command = i2cmws_pkg::CMD_START;
            end
        end else begin
            unique case (r_phase)
                i2cmws_pkg::PH_STARTING: begin
                    if (w_status == i2cmws_pkg::ST_STARTED) begin
                        n_phase = i2cmws_pkg::PH_ADDRESSING;
                        o_res.bus_command = i2cmws_pkg::CMD_TX;
                        o_res.tx_byte     = {r_addr, 1'b0};
                    end else begin
                        n_err   = i2cmws_pkg::ERR_START_FAILED;
                        n_phase = i2cmws_pkg::PH_IDLE;
                        o_res.bus_command = i2cmws_pkg::CMD_STOP;
                    end
                end
                i2cmws_pkg::PH_ADDRESSING: begin
                    if (w_status != i2cmws_pkg::ST_ADDR_ACK) begin
                        n_err   = i2cmws_pkg::ERR_NOT_READY;
                        n_phase = i2cmws_pkg::PH_IDLE;
                        o_res.bus_command = i2cmws_pkg::CMD_STOP;
                    end else if (r_count == '0) begin
                        n_phase = i2cmws_pkg::PH_IDLE;
                        o_res.bus_command = i2cmws_pkg::CMD_STOP;
                    end else begin
                        n_phase = i2cmws_pkg::PH_SENDING;
                        n_idx   = '0;
                        o_res.bus_command = i2cmws_pkg::CMD_TX;
                        o_res.tx_byte     = r_store[0];
                    end
                end
                i2cmws_pkg::PH_SENDING: begin
                    if (w_status != i2cmws_pkg::ST_DATA_ACK) begin
                        n_err   = i2cmws_pkg::ERR_NOT_READY;
                        n_phase = i2cmws_pkg::PH_IDLE;
                        o_res.bus_command = i2cmws_pkg::CMD_STOP;
                    end else if (w_last) begin
                        n_phase = i2cmws_pkg::PH_IDLE;
                        o_res.bus_command = i2cmws_pkg::CMD_STOP;
                    end else begin
                        n_idx = w_next_idx[IW-1:0];
                        o_res.bus_command = i2cmws_pkg::CMD_TX;
                        o_res.tx_byte     = w_next_byte;
                    end
                end
                i2cmws_pkg::PH_IDLE: begin
                    o_res.bus_command = i2cmws_pkg::CMD_ACK;
                end
            endcase
        end

        o_res.error_code = n_err;
        o_res.seq_busy   = (n_phase != i2cmws_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cmws_pkg::PH_IDLE;
            r_err   <= i2cmws_pkg::ERR_NONE;
            r_idx   <= '0;
            r_addr  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_idx   <= n_idx;
            r_addr  <= n_addr;
            r_count <= n_count;
        end
    end

    // bytes beyond the four input fields are stored as zero
    always_ff @(posedge i_clk) begin
        if (i_fire && w_load) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                r_store[i] <= (i < 4) ? w_in_bytes[i % 4] : 8'd0;
            end
        end
    end

endmodule

>>> src/i2cmws_out_stage.sv
// result register driving the output channel
module i2cmws_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cmws_pkg::t_res_item i_res,
    output logic                  o_ready,
    i2cmws_res_if.source          o_res
);

    logic                  r_valid;
    i2cmws_pkg::t_res_item r_res;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.accepted    = r_res.accepted;
    assign o_res.bus_command = r_res.bus_command;
    assign o_res.tx_byte     = r_res.tx_byte;
    assign o_res.error_code  = r_res.error_code;
    assign o_res.seq_busy    = r_res.seq_busy;

endmodule

>>> src/i2cmws_checker.sv
// port-level checks for the i2c master write sequencer, bound to the top level
`include "i2c_master_write_sequencer_unit_macros.svh"

module i2cmws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_res_accepted,
    input logic [2:0] i_res_bus_command,
    input logic [7:0] i_res_tx_byte,
    input logic [1:0] i_res_error_code,
    input logic       i_res_seq_busy
);

    logic [14:0] w_word;
    logic        w_start_busy;
    logic        w_is_tx;

    assign w_word = {i_res_accepted, i_res_bus_command, i_res_tx_byte,
                     i_res_error_code, i_res_seq_busy};
    assign w_start_busy = (i_res_bus_command == i2cmws_pkg::CMD_START) && i_res_seq_busy;
    assign w_is_tx      = (i_res_bus_command == i2cmws_pkg::CMD_TX);

    // result register empties on reset
    `I2CMWS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !i_res_valid)

    // a stalled word holds
    `I2CMWS_ASSERT(a_stall_hold, i_res_valid && !i_res_ready |=> i_res_valid && $stable(w_word))

    // an accepted request always starts a busy transfer
    `I2CMWS_ASSERT(a_accept_start, i_res_valid && i_res_accepted |-> w_start_busy)

    // the byte is only driven for a transmit
    `I2CMWS_ASSERT(a_tx_only, i_res_valid && !w_is_tx |-> i_res_tx_byte == 8'd0)

endmodule

bind i2c_master_write_sequencer_unit i2cmws_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_accepted    (o_res.accepted),
    .i_res_bus_command (o_res.bus_command),
    .i_res_tx_byte     (o_res.tx_byte),
    .i_res_error_code  (o_res.error_code),
    .i_res_seq_busy    (o_res.seq_busy)
);
